/* design/aoc_pkg.sv */
// Shared types and constants of the alpha-over composite window block.
package aoc_pkg;

    // Configuration register width and index width.
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_HEIGHT    = 3'd5;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Reciprocal of 65025 scaled by 2^41 and rounded up. For numerators
    // below 2^24 the top bits of the product give the exact floor quotient.
    localparam logic [MUL_B_W-1:0] RECIP_65025 = 26'd33818121;
    localparam int                 RECIP_SHIFT = 41;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] back_red;
        logic [7:0] back_green;
        logic [7:0] back_blue;
        logic [7:0] back_alpha;
        logic [7:0] fore_red;
        logic [7:0] fore_green;
        logic [7:0] fore_blue;
        logic [7:0] fore_alpha;
    } t_in_pix;

    // Output transaction payload.
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       fore_used;
        logic       frame_end;
    } t_out_pix;

    // Configuration register file contents.
    typedef struct packed {
        logic [CFG_W-1:0] offset_x;
        logic [CFG_W-1:0] offset_y;
        logic [CFG_W-1:0] bottom_width;
        logic [CFG_W-1:0] bottom_height;
        logic [CFG_W-1:0] top_width;
        logic [CFG_W-1:0] top_height;
    } t_cfg;

    // Position status of the current pixel.
    typedef struct packed {
        logic in_win;
        logic frame_end;
    } t_pos;

    // Multiply-accumulate operation codes.
    typedef enum logic [0:0] {
        MAC_LOAD = 1'b0,
        MAC_ACC  = 1'b1
    } t_mac_op;

    typedef struct packed {
        logic    en;
        t_mac_op op;
    } t_mac_ctl;

    // Sequencer states.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PB   = 6'b000010,
        S_MA   = 6'b000100,
        S_MB   = 6'b001000,
        S_MR   = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

endpackage

/* design/alpha_over_composite_window_core.sv */
// Top level of the alpha-over composite window block.
//
// Background pixels enter in raster order on the input channel
// (i_in_valid, o_in_ready, i_in_data), each with the foreground pixel of the
// same position. Results leave on the output channel (o_out_valid,
// i_out_ready, o_out_data), one per input transaction, in order.
// A pixel inside the foreground window steps from acceptance through S_PB,
// then S_MA, S_MB and S_MR for each color channel, to S_FIN; a pixel
// outside the window goes straight to S_FIN. The next pixel is taken only
// once the block is back in S_IDLE. The sequence is set by the
// single shared multiplier: one product for the background alpha weight,
// then three per color channel (two weighted terms and a reciprocal divide).
// Alpha comes from a shift-and-add divide by 255.
// The result sits in an output register, so the next input is accepted
// while it waits; a stalled receiver holds the block only at the final step.
// Reset clears the position counters, the sequencer and the output valid,
// and loads the configuration registers with their reset values.
// The configuration port writes one register per cycle with i_cfg_we.
module alpha_over_composite_window_core
    import aoc_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_pix              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_pix             o_out_data
);

    t_cfg               r_cfg;
    t_state             r_state;
    t_state             n_state;
    logic [1:0]         r_ch;
    t_in_pix            r_in;
    logic               r_inside;
    logic               r_fend;
    logic [15:0]        r_pb;
    logic [7:0]         r_res [2];
    t_out_pix           r_out;
    logic               r_out_valid;

    t_pos               w_pos;
    t_mac_ctl           w_mac_ctl;
    logic [MUL_A_W-1:0] w_mac_a;
    logic [MUL_B_W-1:0] w_mac_b;
    logic [MUL_P_W-1:0] w_acc;
    logic               w_in_fire;
    logic               w_out_free;
    logic [15:0]        w_pa;
    logic [15:0]        w_xa;
    logic [15:0]        w_alpha_sum;
    logic [7:0]         w_alpha;
    logic [7:0]         w_quot;
    logic [7:0]         w_tc;
    logic [7:0]         w_bc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x      <= '0;
            r_cfg.offset_y      <= '0;
            r_cfg.bottom_width  <= CFG_W'(1);
            r_cfg.bottom_height <= CFG_W'(1);
            r_cfg.top_width     <= '0;
            r_cfg.top_height    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFFSET_X:      r_cfg.offset_x      <= i_cfg_data;
                CFG_OFFSET_Y:      r_cfg.offset_y      <= i_cfg_data;
                CFG_BOTTOM_WIDTH:  r_cfg.bottom_width  <= i_cfg_data;
                CFG_BOTTOM_HEIGHT: r_cfg.bottom_height <= i_cfg_data;
                CFG_TOP_WIDTH:     r_cfg.top_width     <= i_cfg_data;
                CFG_TOP_HEIGHT:    r_cfg.top_height    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pixel position, advanced once per accepted transaction.
    aoc_position #(
        .MAX_DIM (MAX_DIM)
    ) u_position (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (w_in_fire),
        .o_pos   (w_pos)
    );

    // Channel operands for the current color step.
    always_comb begin
        case (r_ch)
            2'd0: begin
                w_tc = r_in.fore_red;
                w_bc = r_in.back_red;
            end
            2'd1: begin
                w_tc = r_in.fore_green;
                w_bc = r_in.back_green;
            end
            default: begin
                w_tc = r_in.fore_blue;
                w_bc = r_in.back_blue;
            end
        endcase
    end

    // Foreground weight ta*255 by shift and subtract.
    assign w_pa = {r_in.fore_alpha, 8'd0} - 16'(r_in.fore_alpha);

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mac_ctl.en = 1'b0;
        w_mac_ctl.op = MAC_LOAD;
        w_mac_a      = '0;
        w_mac_b      = '0;
        case (r_state)
            S_PB: begin
                w_mac_ctl.en = 1'b1;
                w_mac_a      = MUL_A_W'(r_in.back_alpha);
                w_mac_b      = MUL_B_W'(8'd255 - r_in.fore_alpha);
            end
            S_MA: begin
                w_mac_ctl.en = 1'b1;
                w_mac_a      = MUL_A_W'(w_pa);
                w_mac_b      = MUL_B_W'(w_tc);
            end
            S_MB: begin
                w_mac_ctl.en = 1'b1;
                w_mac_ctl.op = MAC_ACC;
                w_mac_a      = MUL_A_W'(r_pb);
                w_mac_b      = MUL_B_W'(w_bc);
            end
            S_MR: begin
                w_mac_ctl.en = 1'b1;
                w_mac_a      = w_acc[MUL_A_W-1:0];
                w_mac_b      = RECIP_65025;
            end
            default: ;
        endcase
    end

    aoc_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_mac_ctl),
        .i_a   (w_mac_a),
        .i_b   (w_mac_b),
        .o_acc (w_acc)
    );

    // Quotient of the last reciprocal product.
    assign w_quot = w_acc[RECIP_SHIFT +: 8];

    // Alpha: floor(x / 255) as (x + 1 + x / 256) / 256, exact for x <= 65025.
    assign w_xa        = w_pa + r_pb;
    assign w_alpha_sum = w_xa + 16'd1 + 16'(w_xa[15:8]);
    assign w_alpha     = w_alpha_sum[15:8];

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_fire) n_state = w_pos.in_win ? S_PB : S_FIN;
            S_PB:   n_state = S_MA;
            S_MA:   n_state = S_MB;
            S_MB:   n_state = S_MR;
            S_MR:   n_state = (r_ch == 2'd2) ? S_FIN : S_MA;
            S_FIN:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PB) begin
                r_ch <= '0;
            end else if (r_state == S_MR) begin
                r_ch <= r_ch + 2'd1;
            end
        end
    end

    // Captured pixel, window flags and intermediate results.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in     <= i_in_data;
            r_inside <= w_pos.in_win;
            r_fend   <= w_pos.frame_end;
        end
        if (r_state == S_MA) begin
            if (r_ch == 2'd0) begin
                r_pb <= w_acc[15:0];
            end else begin
                r_res[r_ch[1]] <= w_quot;
            end
        end
    end

    // Output register, loaded at the final step once the receiver is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && w_out_free) begin
            r_out.fore_used <= r_inside;
            r_out.frame_end <= r_fend;
            if (r_inside) begin
                r_out.out_red   <= r_res[0];
                r_out.out_green <= r_res[1];
                r_out.out_blue  <= w_quot;
                r_out.out_alpha <= w_alpha;
            end else begin
                r_out.out_red   <= r_in.back_red;
                r_out.out_green <= r_in.back_green;
                r_out.out_blue  <= r_in.back_blue;
                r_out.out_alpha <= r_in.back_alpha;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A new result is only ever loaded from the final sequencer step.
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("output became valid outside the final step");

    // Reciprocal products of a blended pixel never overflow the quotient.
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MA && r_ch != 2'd0) || (r_state == S_FIN && r_inside))
        |-> (w_acc[MUL_P_W-1] == 1'b0))
        else $error("reciprocal product exceeds quotient range");

    // A pixel outside the window goes straight to the final step.
    a_pass_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !w_pos.in_win) |=> (r_state == S_FIN))
        else $error("pass-through pixel entered the blend sequence");

endmodule

/* design/aoc_mac.sv */
// Shared multiply-accumulate unit with a registered result.
module aoc_mac
    import aoc_pkg::*;
(
    input  logic               i_clk,
    input  t_mac_ctl           i_ctl,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_acc
);

    logic [MUL_P_W-1:0] r_acc;
    logic [MUL_P_W-1:0] n_acc;
    logic [MUL_P_W-1:0] w_prod;

    // One product per cycle while enabled, either loaded or added to the running sum.
    assign w_prod = MUL_P_W'(i_a) * MUL_P_W'(i_b);

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.en) begin
            case (i_ctl.op)
                MAC_LOAD: n_acc = w_prod;
                MAC_ACC:  n_acc = r_acc + w_prod;
                default:  n_acc = w_prod;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

/* design/aoc_position.sv */
// Raster column and row counters with the foreground window test.
module aoc_position
    import aoc_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_step,
    output t_pos o_pos
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int WW = (CW + 1 > CFG_W + 1) ? CW + 1 : CFG_W + 1;

    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;
    logic [WW-1:0] w_width;
    logic [WW-1:0] w_height;
    logic [WW-1:0] w_col;
    logic [WW-1:0] w_row;
    logic          w_last_col;
    logic          w_last_row;
    logic          w_in_x;
    logic          w_in_y;

    // Clamp a frame dimension to the range one to MAX_DIM.
    function automatic logic [WW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [WW-1:0] ext;
        ext = WW'(v);
        if (ext == '0) begin
            return WW'(1);
        end else if (ext > WW'(MAX_DIM)) begin
            return WW'(MAX_DIM);
        end
        return ext;
    endfunction

    assign w_width  = clamp_dim(i_cfg.bottom_width);
    assign w_height = clamp_dim(i_cfg.bottom_height);
    assign w_col    = WW'(r_col);
    assign w_row    = WW'(r_row);

    // Window test against the current position.
    assign w_in_x = (w_col >= WW'(i_cfg.offset_x)) &&
                    (w_col < WW'(i_cfg.offset_x) + WW'(i_cfg.top_width));
    assign w_in_y = (w_row >= WW'(i_cfg.offset_y)) &&
                    (w_row < WW'(i_cfg.offset_y) + WW'(i_cfg.top_height));

    // A counter at or past the last position ends its line or frame.
    assign w_last_col = (w_col + WW'(1)) >= w_width;
    assign w_last_row = (w_row + WW'(1)) >= w_height;

    assign o_pos.in_win    = w_in_x && w_in_y;
    assign o_pos.frame_end = w_last_col && w_last_row;

    // Next position after one pixel.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_last_row ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

/* test/alpha_over_checker.sv */
// Checker that predicts and compares every pixel of the alpha-over composite window block.
module alpha_over_checker
    import aoc_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_pix              i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_pix             i_out_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // Shadow copy of the configuration registers and the raster position.
    t_cfg        window_regs;
    int unsigned column_pos;
    int unsigned row_pos;

    // Composited pixels still waiting for their result transaction.
    t_out_pix expected_pixels[$];
    int       fail_count;
    int       pending_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Foreground-over-background color term, exact floor of the divide by 255*255.
    function automatic logic [7:0] blend_color(int unsigned fc, int unsigned fa,
                                               int unsigned bc, int unsigned ba);
        int unsigned num;
        num = fa * fc * 255 + ba * (255 - fa) * bc;
        return 8'(num / 65025);
    endfunction

    // A zero size counts as one and a size above the maximum as the maximum.
    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_pix    exp_pix;
        t_out_pix    pred;
        int unsigned w;
        int unsigned h;
        int unsigned fa;
        int unsigned ba;
        logic        in_window;
        logic        last_col;
        logic        last_row;

        if (!i_rst_n) begin
            window_regs.offset_x      = '0;
            window_regs.offset_y      = '0;
            window_regs.bottom_width  = 13'd1;
            window_regs.bottom_height = 13'd1;
            window_regs.top_width     = '0;
            window_regs.top_height    = '0;
            column_pos = 0;
            row_pos    = 0;
            expected_pixels.delete();
            fail_count = 0;
        end else begin
            // Compare a result transaction with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result transaction arrived with no pixel expected");
                    fail_count++;
                end else begin
                    exp_pix = expected_pixels.pop_front();
                    check_field("out_red",   exp_pix.out_red,   i_out_data.out_red);
                    check_field("out_green", exp_pix.out_green, i_out_data.out_green);
                    check_field("out_blue",  exp_pix.out_blue,  i_out_data.out_blue);
                    check_field("out_alpha", exp_pix.out_alpha, i_out_data.out_alpha);
                    check_field("fore_used", exp_pix.fore_used, i_out_data.fore_used);
                    check_field("frame_end", exp_pix.frame_end, i_out_data.frame_end);
                end
            end

            // Register writes leave the raster position alone.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OFFSET_X:      window_regs.offset_x      = i_cfg_data;
                    CFG_OFFSET_Y:      window_regs.offset_y      = i_cfg_data;
                    CFG_BOTTOM_WIDTH:  window_regs.bottom_width  = i_cfg_data;
                    CFG_BOTTOM_HEIGHT: window_regs.bottom_height = i_cfg_data;
                    CFG_TOP_WIDTH:     window_regs.top_width     = i_cfg_data;
                    CFG_TOP_HEIGHT:    window_regs.top_height    = i_cfg_data;
                    default: ;
                endcase
            end

            // Predict the composited pixel for an accepted input transaction.
            if (i_in_valid && i_in_ready) begin
                w  = clamp_dim(window_regs.bottom_width);
                h  = clamp_dim(window_regs.bottom_height);
                fa = 32'(i_in_data.fore_alpha);
                ba = 32'(i_in_data.back_alpha);
                in_window = column_pos >= window_regs.offset_x &&
                            column_pos < int'(window_regs.offset_x) +
                                         int'(window_regs.top_width) &&
                            row_pos >= window_regs.offset_y &&
                            row_pos < int'(window_regs.offset_y) +
                                      int'(window_regs.top_height);
                if (in_window) begin
                    pred.out_red   = blend_color(32'(i_in_data.fore_red), fa,
                                                 32'(i_in_data.back_red), ba);
                    pred.out_green = blend_color(32'(i_in_data.fore_green), fa,
                                                 32'(i_in_data.back_green), ba);
                    pred.out_blue  = blend_color(32'(i_in_data.fore_blue), fa,
                                                 32'(i_in_data.back_blue), ba);
                    pred.out_alpha = 8'((fa * 255 + ba * (255 - fa)) / 255);
                end else begin
                    pred.out_red   = i_in_data.back_red;
                    pred.out_green = i_in_data.back_green;
                    pred.out_blue  = i_in_data.back_blue;
                    pred.out_alpha = i_in_data.back_alpha;
                end
                // A position at or past the last column or row wraps.
                last_col = column_pos + 1 >= w;
                last_row = row_pos + 1 >= h;
                pred.fore_used = in_window;
                pred.frame_end = last_col && last_row;
                if (last_col) begin
                    column_pos = 0;
                    row_pos    = last_row ? 0 : row_pos + 1;
                end else begin
                    column_pos = column_pos + 1;
                end
                expected_pixels.push_back(pred);
            end
        end
        pending_count = expected_pixels.size();
    end

endmodule

/* test/alpha_over_composite_window_core_tb.sv */
// Testbench top for the alpha-over composite window block: stimulus, idling and verdict.
module alpha_over_composite_window_core_tb;
    import aoc_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 24;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_PER_MODE = 480;
    localparam int BURST_PIXELS    = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd6;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    t_in_pix              in_data;
    logic                 out_valid;
    logic                 out_ready;
    t_out_pix             out_data;
    int                   fail_count;
    int                   pending;
    int unsigned          snd_idle;
    int unsigned          rcv_idle;
    logic                 hold_req;
    int                   quiet_cycles = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    alpha_over_composite_window_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    alpha_over_checker composite_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Receiver side: random back-pressure, plus one long hold-off on request.
    initial begin : receiver
        int unsigned idle_now;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            idle_now = rcv_idle;
            if (hold_req) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready <= ($urandom_range(99) >= idle_now);
            end else begin
                @(negedge clk);
                out_ready <= ($urandom_range(99) >= idle_now);
            end
        end
    end

    // The run is aborted when no transaction moves for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offer one pixel after a random idle gap; returns at the falling edge after
    // acceptance with valid still high.
    task automatic send_pixel(input t_in_pix px);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted pixel has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy,
                                input logic [CFG_W-1:0] bw, input logic [CFG_W-1:0] bh,
                                input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_BOTTOM_WIDTH, bw);
        write_reg(CFG_BOTTOM_HEIGHT, bh);
        write_reg(CFG_TOP_WIDTH, tw);
        write_reg(CFG_TOP_HEIGHT, th);
    endtask

    // Random pixel with channels often pinned to zero or full scale.
    function automatic t_in_pix random_pixel();
        logic [63:0] v;
        for (int k = 0; k < 8; k++) begin
            case ($urandom_range(7))
                0:       v[8*k +: 8] = 8'h00;
                1:       v[8*k +: 8] = 8'hFF;
                default: v[8*k +: 8] = 8'($urandom);
            endcase
        end
        return t_in_pix'(v);
    endfunction

    initial begin : stimulus
        int               mode;
        int               sent;
        int               n;
        int               kind;
        logic [CFG_W-1:0] bw;
        logic [CFG_W-1:0] bh;
        logic [CFG_W-1:0] ox;
        logic [CFG_W-1:0] oy;
        logic [CFG_W-1:0] tw;
        logic [CFG_W-1:0] th;

        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data  = '0;
        snd_idle = 0;
        rcv_idle = 0;
        hold_req = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset geometry: one-pixel frame and an empty window.
        send_pixel({32'h11223344, 32'hFFFFFFFF});
        send_pixel({32'hFFFFFFFF, 32'h00000000});
        wait_drained();

        // Zero background size counts as one; a full-size window blends every pixel.
        set_geometry(13'd0, 13'd0, 13'd0, 13'd0, 13'd4096, 13'd4096);
        send_pixel({32'h00000000, 32'h00000000});
        send_pixel({32'hFFFFFFFF, 32'hFFFFFFFF});
        send_pixel({32'hFFFFFFFF, 32'hFFFFFF00});
        send_pixel({32'h00000000, 32'hFFFFFFFF});
        send_pixel({32'h80C0FF00, 32'h102030FF});
        send_pixel({32'h12345680, 32'h9ABCDEF0});
        send_pixel({32'hAA55AA55, 32'h55AA55AA});
        send_pixel({32'hFFFFFF01, 32'h010101FE});
        wait_drained();

        // Window running past the right edge of a 4x2 frame, one full frame.
        set_geometry(13'd2, 13'd1, 13'd4, 13'd2, 13'd4096, 13'd1);
        repeat (8) send_pixel(random_pixel());
        wait_drained();

        // Oversize background, offsets at the far corner, and an unused index.
        set_geometry(13'd4096, 13'd4096, 13'h1FFF, 13'h1FFF, 13'd4096, 13'd4096);
        write_reg(CFG_SPARE_IDX, 13'h1FFF);
        repeat (3) send_pixel(random_pixel());
        wait_drained();

        // Shrinking the frame mid-row: the column past the new width ends the frame.
        write_reg(CFG_BOTTOM_WIDTH, 13'd2);
        write_reg(CFG_BOTTOM_HEIGHT, 13'd1);
        repeat (2) send_pixel(random_pixel());
        wait_drained();

        // Random phases under three idling schemes, new geometry per burst.
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0:       begin snd_idle = 27; rcv_idle = 60; end
                1:       begin snd_idle = 60; rcv_idle = 27; end
                default: begin snd_idle = 0;  rcv_idle = 0;  end
            endcase
            sent = 0;
            while (sent < RANDOM_PER_MODE) begin
                kind = int'($urandom_range(0, 9));
                bw = CFG_W'($urandom_range(1, 12));
                bh = CFG_W'($urandom_range(1, 8));
                ox = CFG_W'($urandom_range(0, 13));
                oy = CFG_W'($urandom_range(0, 9));
                tw = CFG_W'($urandom_range(0, 14));
                th = CFG_W'($urandom_range(0, 9));
                case (kind)
                    0: begin
                        if ($urandom_range(1))
                            bw = '0;
                        else
                            bh = '0;
                    end
                    1: bw = CFG_W'($urandom_range(4097, 8191));
                    2: begin
                        bw = CFG_W'($urandom_range(1, 4096));
                        bh = CFG_W'($urandom_range(1, 4096));
                        ox = CFG_W'($urandom_range(0, 4096));
                        tw = CFG_W'($urandom_range(0, 4096));
                    end
                    3: begin
                        ox = CFG_W'($urandom_range(0, 4096));
                        oy = CFG_W'($urandom_range(0, 4096));
                        tw = 13'd4096;
                        th = 13'd4096;
                    end
                    4: begin
                        tw = 13'd4096;
                        th = 13'd4096;
                    end
                    default: ;
                endcase
                set_geometry(ox, oy, bw, bh, tw, th);

                n = int'($urandom_range(16, 90));
                // First phase: hold the receiver off so the block fills and stalls.
                if (mode == 0 && sent == 0) begin
                    hold_req <= 1'b1;
                    @(negedge clk);
                    hold_req <= 1'b0;
                    n = BURST_PIXELS;
                end
                repeat (n) send_pixel(random_pixel());
                sent += n;
                wait_drained();
            end
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
